// ===== rtl/subtractive_lagged_rng_unit_assert.svh =====
// Assertion macros for the subtractive random generator top level.
`ifndef SUBTRACTIVE_LAGGED_RNG_UNIT_ASSERT_SVH
`define SUBTRACTIVE_LAGGED_RNG_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define SLRNG_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`define SLRNG_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");
`else
`define SLRNG_ASSERT(lbl, clk, rstn, prop)
`define SLRNG_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== rtl/slrng_pkg.sv =====
// Types and constants of the subtractive random generator.
package slrng_pkg;

    localparam int TABLE_LEN    = 55;
    localparam int VALUE_W      = 30;
    localparam int SEED_W       = 28;
    localparam int IDX_W        = 6;
    localparam int SCATTER_STEP = 21;
    localparam int LAG_OFFSET   = 30;
    localparam int LAG_START    = 31;
    localparam int MIX_PASSES   = 4;

    localparam logic [VALUE_W-1:0] MODULUS   = 30'd1000000000;
    localparam logic [SEED_W-1:0]  SEED_BASE = 28'd161803398;

    typedef struct packed {
        logic              kind;
        logic [SEED_W-1:0] seed;
    } t_in;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               was_reseeded;
    } t_out;

endpackage

// ===== rtl/subtractive_lagged_rng_unit.sv =====
// Top level of the subtractive random generator with its table and sequencer.
//
// Usage: one input word per request on the in channel (kind, seed) and one
// result word per request on the out channel (value, was_reseeded). Both
// channels use valid/ready handshakes.
// A draw request (kind 0 on a seeded table) goes from acceptance to the
// result register through a table read of both ring entries, then a write
// of the difference together with the result load. The sequencer then
// returns to idle, so a new draw is accepted only once the last is done.
// The table has a two-read, one-write port; one subtractor serves all steps.
// A reseed request (kind 1, or the first request after reset) adds the
// seeding walk before its draw: a write of the top entry, 54 scatter steps
// and 4 passes of 55 mixing steps, each a table read and then a write.
// Only one request is in work at a time; the in channel is ready when idle.
// Reset clears the sequencer, the ring indices and the seeded flag; the
// table itself is filled by the first request, which always seeds.
// The result sits in an output register; a new request is accepted while it
// waits, and its write-back stalls until the receiver has taken the old one.
module subtractive_lagged_rng_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  slrng_pkg::t_in  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output slrng_pkg::t_out o_out_data
);
    import slrng_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SEED_TOP = 3'd1;
    localparam logic [2:0] ST_SCAT     = 3'd2;
    localparam logic [2:0] ST_MIX_RD   = 3'd3;
    localparam logic [2:0] ST_MIX_WR   = 3'd4;
    localparam logic [2:0] ST_DRW_RD   = 3'd5;
    localparam logic [2:0] ST_DRW_WR   = 3'd6;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_LEN);
    localparam logic [IDX_W-1:0] LAST_SCAT = IDX_W'(TABLE_LEN - 1);
    localparam logic [1:0]       LAST_PASS = 2'(MIX_PASSES - 1);

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] res;
        if (idx >= LAST_IDX || idx == '0) begin
            res = IDX_W'(1);
        end else begin
            res = idx + IDX_W'(1);
        end
        return res;
    endfunction

    logic [VALUE_W-1:0] mem [0:TABLE_LEN-1];

    logic [2:0]         r_state, n_state;
    logic [IDX_W-1:0]   r_step, n_step;
    logic [1:0]         r_pass, n_pass;
    logic [IDX_W-1:0]   r_pos, n_pos;
    logic [VALUE_W-1:0] r_cur, n_cur;
    logic [VALUE_W-1:0] r_prev, n_prev;
    logic [IDX_W-1:0]   r_lead, n_lead;
    logic [IDX_W-1:0]   r_lag, n_lag;
    logic               r_seeded, n_seeded;
    logic               r_resd, n_resd;
    logic               r_out_valid, n_out_valid;
    t_out               r_out, n_out;
    logic [VALUE_W-1:0] r_rd_a, r_rd_b;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr_a, rd_addr_b;

    logic [VALUE_W-1:0] sub_a, sub_b, sub_diff;
    logic [SEED_W-1:0]  seed_sat;
    logic [IDX_W:0]     pos_sum, other_sum;
    logic [IDX_W-1:0]   adv_lead, adv_lag;
    logic               in_take, out_free;

    slrng_submod u_submod (
        .i_a    (sub_a),
        .i_b    (sub_b),
        .o_diff (sub_diff)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_take  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign seed_sat = (i_in_data.seed > SEED_BASE) ? SEED_BASE : i_in_data.seed;
    assign pos_sum  = {1'b0, r_pos} + (IDX_W+1)'(SCATTER_STEP);
    assign other_sum = {1'b0, r_step} + (IDX_W+1)'(LAG_OFFSET);
    assign adv_lead = advance(r_lead);
    assign adv_lag  = advance(r_lag);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_pass      = r_pass;
        n_pos       = r_pos;
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_lead      = r_lead;
        n_lag       = r_lag;
        n_seeded    = r_seeded;
        n_resd      = r_resd;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = r_prev;
        rd_en       = 1'b0;
        rd_addr_a   = '0;
        rd_addr_b   = '0;
        sub_a       = r_rd_a;
        sub_b       = r_rd_b;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    if (i_in_data.kind || !r_seeded) begin
                        n_cur    = {{(VALUE_W-SEED_W){1'b0}}, SEED_BASE - seed_sat};
                        n_prev   = VALUE_W'(1);
                        n_pos    = IDX_W'(SCATTER_STEP);
                        n_step   = IDX_W'(1);
                        n_lead   = '0;
                        n_lag    = IDX_W'(LAG_START);
                        n_seeded = 1'b1;
                        n_resd   = 1'b1;
                        n_state  = ST_SEED_TOP;
                    end else begin
                        n_resd  = 1'b0;
                        n_state = ST_DRW_RD;
                    end
                end
            end
            ST_SEED_TOP: begin
                mem_we    = 1'b1;
                mem_waddr = LAST_IDX - IDX_W'(1);
                mem_wdata = r_cur;
                n_state   = ST_SCAT;
            end
            ST_SCAT: begin
                sub_a     = r_cur;
                sub_b     = r_prev;
                mem_we    = 1'b1;
                mem_waddr = r_pos - IDX_W'(1);
                mem_wdata = r_prev;
                n_prev    = sub_diff;
                n_cur     = r_prev;
                n_pos     = (pos_sum >= (IDX_W+1)'(TABLE_LEN))
                          ? IDX_W'(pos_sum - (IDX_W+1)'(TABLE_LEN)) : pos_sum[IDX_W-1:0];
                if (r_step == LAST_SCAT) begin
                    n_step  = IDX_W'(1);
                    n_pass  = '0;
                    n_state = ST_MIX_RD;
                end else begin
                    n_step = r_step + IDX_W'(1);
                end
            end
            ST_MIX_RD: begin
                rd_en     = 1'b1;
                rd_addr_a = r_step - IDX_W'(1);
                rd_addr_b = (other_sum >= (IDX_W+1)'(TABLE_LEN))
                          ? IDX_W'(other_sum - (IDX_W+1)'(TABLE_LEN)) : other_sum[IDX_W-1:0];
                n_state   = ST_MIX_WR;
            end
            ST_MIX_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_step - IDX_W'(1);
                mem_wdata = sub_diff;
                n_state   = ST_MIX_RD;
                if (r_step == LAST_IDX) begin
                    n_step = IDX_W'(1);
                    n_pass = r_pass + 2'd1;
                    if (r_pass == LAST_PASS) begin
                        n_state = ST_DRW_RD;
                    end
                end else begin
                    n_step = r_step + IDX_W'(1);
                end
            end
            ST_DRW_RD: begin
                rd_en     = 1'b1;
                rd_addr_a = adv_lead - IDX_W'(1);
                rd_addr_b = adv_lag - IDX_W'(1);
                n_lead    = adv_lead;
                n_lag     = adv_lag;
                n_state   = ST_DRW_WR;
            end
            ST_DRW_WR: begin
                if (out_free) begin
                    mem_we      = 1'b1;
                    mem_waddr   = r_lead - IDX_W'(1);
                    mem_wdata   = sub_diff;
                    n_out_valid = 1'b1;
                    n_out.value = sub_diff;
                    n_out.was_reseeded = r_resd;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_a <= mem[rd_addr_a];
            r_rd_b <= mem[rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_pass      <= '0;
            r_lead      <= '0;
            r_lag       <= IDX_W'(LAG_START);
            r_seeded    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_pass      <= n_pass;
            r_lead      <= n_lead;
            r_lag       <= n_lag;
            r_seeded    <= n_seeded;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_cur  <= n_cur;
        r_prev <= n_prev;
        r_resd <= n_resd;
        r_out  <= n_out;
    end

`include "subtractive_lagged_rng_unit_assert.svh"

    `SLRNG_ASSERT(a_value_range, i_clk, i_rst_n, o_out_valid |-> (o_out_data.value < MODULUS))
    `SLRNG_ASSERT(a_reseed_start, i_clk, i_rst_n, (in_take && i_in_data.kind) |=> (r_state == ST_SEED_TOP))
    `SLRNG_ASSERT(a_out_source, i_clk, i_rst_n, $rose(o_out_valid) |-> ($past(r_state) == ST_DRW_WR))
    `SLRNG_NEVER(a_lead_range, i_clk, i_rst_n, r_seeded && (r_state == ST_IDLE) && (r_lead == '0 || r_lead > LAST_IDX))

endmodule

// ===== rtl/slrng_submod.sv =====
// Shared modular subtractor: (a - b) mod 10^9 for operands below 10^9.
module slrng_submod (
    input  logic [slrng_pkg::VALUE_W-1:0] i_a,
    input  logic [slrng_pkg::VALUE_W-1:0] i_b,
    output logic [slrng_pkg::VALUE_W-1:0] o_diff
);
    import slrng_pkg::*;

    logic [VALUE_W:0] wrap_sum;

    assign wrap_sum = {1'b0, i_a} + {1'b0, MODULUS} - {1'b0, i_b};
    assign o_diff   = (i_a >= i_b) ? (i_a - i_b) : wrap_sum[VALUE_W-1:0];

endmodule
